// ----- rtl/core/rtcd_pkg.sv -----
// Shared types, codes and keyword tables for the RGB text command decoder.
`timescale 1ns / 1ps

package rtcd_pkg;

    localparam int unsigned StateW = 4;
    localparam int unsigned ColorW = 2;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned DutyW  = 16;
    localparam int unsigned IdxW   = 3;

    // parser phases
    localparam logic [StateW-1:0] ST_START  = 4'd0;
    localparam logic [StateW-1:0] ST_WORD   = 4'd1;
    localparam logic [StateW-1:0] ST_WS     = 4'd2;
    localparam logic [StateW-1:0] ST_SIGN   = 4'd3;
    localparam logic [StateW-1:0] ST_DIGITS = 4'd4;
    localparam logic [StateW-1:0] ST_OFF    = 4'd5;
    localparam logic [StateW-1:0] ST_GOT    = 4'd6;
    localparam logic [StateW-1:0] ST_FAIL   = 4'd7;

    // target selection
    localparam logic [ColorW-1:0] COLOR_RED   = 2'd0;
    localparam logic [ColorW-1:0] COLOR_GREEN = 2'd1;
    localparam logic [ColorW-1:0] COLOR_BLUE  = 2'd2;
    localparam logic [ColorW-1:0] COLOR_OFF   = 2'd3;

    // characters
    localparam logic [ByteW-1:0] CH_CR    = 8'd13;
    localparam logic [ByteW-1:0] CH_LF    = 8'd10;
    localparam logic [ByteW-1:0] CH_TAB   = 8'd9;
    localparam logic [ByteW-1:0] CH_SPACE = 8'd32;
    localparam logic [ByteW-1:0] CH_PLUS  = 8'd43;
    localparam logic [ByteW-1:0] CH_MINUS = 8'd45;
    localparam logic [ByteW-1:0] CH_ZERO  = 8'd48;
    localparam logic [ByteW-1:0] CH_NINE  = 8'd57;
    localparam logic [ByteW-1:0] CH_R     = 8'd114;
    localparam logic [ByteW-1:0] CH_G     = 8'd103;
    localparam logic [ByteW-1:0] CH_B     = 8'd98;
    localparam logic [ByteW-1:0] CH_O     = 8'd111;

    typedef struct packed {
        logic [ByteW-1:0] red;
        logic [ByteW-1:0] green;
        logic [ByteW-1:0] blue;
    } t_levels;

    // keyword length per target
    function automatic logic [ByteW-1:0] word_len(input logic [ColorW-1:0] t);
        logic [ByteW-1:0] len;
        case (t)
            COLOR_RED:   len = 8'd3;
            COLOR_GREEN: len = 8'd5;
            COLOR_BLUE:  len = 8'd4;
            default:     len = 8'd3;
        endcase
        return len;
    endfunction

    // character idx of the keyword for target t
    function automatic logic [ByteW-1:0] word_char(input logic [ColorW-1:0] t,
                                                   input logic [IdxW-1:0]   idx);
        logic [ByteW-1:0] ch;
        ch = 8'd0;
        case (t)
            COLOR_RED: begin
                case (idx)
                    3'd0:    ch = "r";
                    3'd1:    ch = "e";
                    3'd2:    ch = "d";
                    default: ch = 8'd0;
                endcase
            end
            COLOR_GREEN: begin
                case (idx)
                    3'd0:    ch = "g";
                    3'd1:    ch = "r";
                    3'd2:    ch = "e";
                    3'd3:    ch = "e";
                    3'd4:    ch = "n";
                    default: ch = 8'd0;
                endcase
            end
            COLOR_BLUE: begin
                case (idx)
                    3'd0:    ch = "b";
                    3'd1:    ch = "l";
                    3'd2:    ch = "u";
                    3'd3:    ch = "e";
                    default: ch = 8'd0;
                endcase
            end
            default: begin
                case (idx)
                    3'd0:    ch = "o";
                    3'd1:    ch = "f";
                    3'd2:    ch = "f";
                    default: ch = 8'd0;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/core/rtcd_parser.sv -----
// Line parser: keyword match, number capture and the three color levels.
`timescale 1ns / 1ps

module rtcd_parser (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [7:0]              i_byte,
    output rtcd_pkg::t_levels       o_next_levels
);
    import rtcd_pkg::*;

    logic [StateW-1:0] r_state, n_state;
    logic [ColorW-1:0] r_color, n_color;
    logic [ByteW-1:0]  r_acc,   n_acc;
    logic              r_neg,   n_neg;
    t_levels           r_lvl,   n_lvl;

    logic              is_ws;
    logic              is_digit;
    logic [ByteW-1:0]  digit;
    logic [ByteW-1:0]  value;
    logic [ByteW-1:0]  acc_inc;
    logic [ByteW-1:0]  acc_x10;
    logic [ByteW-1:0]  len;

    always_comb begin
        is_ws    = (i_byte == CH_SPACE) || (i_byte >= CH_TAB && i_byte <= CH_CR);
        is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        digit    = i_byte - CH_ZERO;
        value    = r_neg ? (8'd0 - r_acc) : r_acc;
        acc_inc  = r_acc + 8'd1;
        acc_x10  = {r_acc[4:0], 3'b000} + {r_acc[6:0], 1'b0};
        len      = word_len(r_color);

        n_state = r_state;
        n_color = r_color;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_lvl   = r_lvl;

        if (i_accept) begin
            if (i_byte == CH_CR) begin
                // end of line: commit a captured number or an exact "off"
                if (r_state == ST_DIGITS || r_state == ST_GOT) begin
                    case (r_color)
                        COLOR_RED:   n_lvl.red   = value;
                        COLOR_GREEN: n_lvl.green = value;
                        COLOR_BLUE:  n_lvl.blue  = value;
                        default:     n_lvl       = r_lvl;
                    endcase
                end else if (r_state == ST_OFF) begin
                    n_lvl = '0;
                end
                n_state = ST_START;
                n_color = COLOR_RED;
                n_acc   = '0;
                n_neg   = 1'b0;
            end else begin
                case (r_state)
                    ST_START: begin
                        n_state = ST_WORD;
                        n_acc   = 8'd1;
                        if (i_byte == CH_R)      n_color = COLOR_RED;
                        else if (i_byte == CH_G) n_color = COLOR_GREEN;
                        else if (i_byte == CH_B) n_color = COLOR_BLUE;
                        else if (i_byte == CH_O) n_color = COLOR_OFF;
                        else begin
                            n_state = ST_FAIL;
                            n_acc   = r_acc;
                        end
                    end
                    ST_WORD: begin
                        if (r_acc >= len || i_byte != word_char(r_color, r_acc[IdxW-1:0])) begin
                            n_state = ST_FAIL;
                        end else if (acc_inc == len) begin
                            n_acc   = '0;
                            n_state = (r_color == COLOR_OFF) ? ST_OFF : ST_WS;
                        end else begin
                            n_acc = acc_inc;
                        end
                    end
                    ST_WS: begin
                        if (is_ws) begin
                            n_state = r_state;
                        end else if (i_byte == CH_PLUS) begin
                            n_state = ST_SIGN;
                        end else if (i_byte == CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_state = ST_SIGN;
                        end else if (is_digit) begin
                            n_acc   = digit;
                            n_state = ST_DIGITS;
                        end else begin
                            n_state = ST_FAIL;
                        end
                    end
                    ST_SIGN: begin
                        if (is_digit) begin
                            n_acc   = digit;
                            n_state = ST_DIGITS;
                        end else begin
                            n_state = ST_FAIL;
                        end
                    end
                    ST_DIGITS: begin
                        if (is_digit) n_acc = acc_x10 + digit;
                        else          n_state = ST_GOT;
                    end
                    ST_GOT: begin
                        n_state = r_state;
                    end
                    default: begin
                        // "off" followed by anything, and failed lines
                        n_state = ST_FAIL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_color <= COLOR_RED;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_lvl   <= '0;
        end else begin
            r_state <= n_state;
            r_color <= n_color;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_lvl   <= n_lvl;
        end
    end

    assign o_next_levels = n_lvl;

endmodule

// ----- rtl/core/rtcd_out_stage.sv -----
// Result register: echo beat, trailing newline beat and squared PWM duties.
`timescale 1ns / 1ps

module rtcd_out_stage (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [7:0]              i_byte,
    input  rtcd_pkg::t_levels       i_levels,
    output logic                    o_can_accept,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [55:0]             o_m_tdata,
    output logic                    o_m_tlast
);
    import rtcd_pkg::*;

    logic             r_valid;
    logic             r_nl_pend;
    logic [ByteW-1:0] r_tx;
    logic             r_last;
    logic [DutyW-1:0] r_red, r_green, r_blue;
    logic             take;

    assign take         = r_valid && i_m_tready;
    assign o_can_accept = !r_nl_pend && (!r_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_nl_pend <= 1'b0;
        end else if (i_accept) begin
            r_valid   <= 1'b1;
            r_nl_pend <= (i_byte == CH_CR);
        end else if (take) begin
            // a pending newline goes out right after the echoed return
            r_valid   <= r_nl_pend;
            r_nl_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_tx    <= i_byte;
            r_last  <= (i_byte != CH_CR);
            r_red   <= DutyW'(i_levels.red)   * DutyW'(i_levels.red);
            r_green <= DutyW'(i_levels.green) * DutyW'(i_levels.green);
            r_blue  <= DutyW'(i_levels.blue)  * DutyW'(i_levels.blue);
        end else if (take && r_nl_pend) begin
            r_tx   <= CH_LF;
            r_last <= 1'b1;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_blue, r_green, r_red, r_tx};
    assign o_m_tlast  = r_last;

endmodule

// ----- rtl/core/rgb_text_command_decoder_top.sv -----
// Top level of the RGB text command decoder.
`timescale 1ns / 1ps

// Takes received characters one beat at a time and parses lines ended by
// carriage return: "red N", "green N", "blue N" (optional whitespace and
// sign, N taken modulo 256) set one 8-bit level, and a line of exactly "off"
// clears all three. Every character is echoed as one output beat; a return
// gives two beats, the return (tlast low) and then a newline (tlast high).
// Every beat carries the squares of the levels after that character was
// parsed. A character is accepted every cycle while the output is taken;
// a return holds the input until the return beat has been taken, so that
// the single output register can send the newline beat.
module rgb_text_command_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [7:0] tx_byte, [23:8] red_duty,
                                     // [39:24] green_duty, [55:40] blue_duty
    output logic        o_m_tlast    // last_of_run
);
    import rtcd_pkg::*;

    logic    can_accept;
    logic    accept;
    t_levels next_levels;

    assign o_s_tready = can_accept;
    assign accept     = i_s_tvalid && can_accept;

    rtcd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_byte        (i_s_tdata),
        .o_next_levels (next_levels)
    );

    rtcd_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (i_s_tdata),
        .i_levels     (next_levels),
        .o_can_accept (can_accept),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tlast    (o_m_tlast)
    );

endmodule
